### rtl/eled_pkg.sv
// shared constants and types of the early-late envelope discriminator
`default_nettype none
package eled_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int FRACTION_BITS_DEF = 15;

  localparam int OUT_W       = 16;
  localparam int OUT_MAX     = 32767;
  localparam int OUT_NEG_LIM = 32768;

  typedef struct packed {
    logic neg;
    logic zero;
  } eled_flags_t;

endpackage
`default_nettype wire

### rtl/early_late_envelope_discriminator_top.sv
// normalized early-minus-late envelope code discriminator, top level
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   early/late in-phase and quadrature sums
//   output   out        out_valid_o / out_stall_i code_error_o
//
// one item per cycle while the output is not stalled
// items pass through the square root cell chain (one root bit per cell)
// and the divider cell chain (one quotient bit per cell)
// reset clears the stage valid bits and the output buffer, no clearing pass
// a stalled output fills the skid entry, then the whole pipeline holds
// and in_stall_o stays high until the output item is taken
`default_nettype none
module early_late_envelope_discriminator_top
  import eled_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] early_in_phase_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] early_quadrature_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] late_in_phase_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] late_quadrature_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [OUT_W-1:0]             code_error_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int XW   = 2 * SW;
  localparam int RW   = SW + 2;
  localparam int SUMW = SW + 1;
  localparam int DW   = SW + 3;
  localparam int MW   = FB + 1;
  localparam int EW   = (MW > OUT_W + 1) ? MW : OUT_W + 1;
  localparam int NST  = 4 + SW + FB;
  localparam int SQ0  = 3;
  localparam int PREP = 3 + SW;

  function automatic logic [SW-1:0] magnitude(input logic [SW-1:0] v);
    return v[SW-1] ? SW'(~v + SW'(1)) : v;
  endfunction

  logic           en;
  logic [NST-1:0] vld_q;

  logic [SW-1:0]  mag_q [4];
  logic [XW-1:0]  sq_q  [4];
  logic [XW-1:0]  rad_q [2];

  logic [RW-1:0]  s_rem  [2][SW+1];
  logic [SW-1:0]  s_root [2][SW+1];
  logic [XW-1:0]  s_x    [2][SW+1];

  logic [SW-1:0]  env_e;
  logic [SW-1:0]  env_l;
  logic [DW-1:0]  d_rem   [FB+1];
  logic [FB-1:0]  d_q     [FB+1];
  logic [SUMW-1:0] d_s    [FB+1];
  eled_flags_t    d_flags [FB+1];

  logic [SUMW-1:0] prep_s;
  eled_flags_t     prep_flags;
  logic [SW-1:0]   prep_diff;

  logic            rnd;
  logic [MW-1:0]   m;
  logic [EW-1:0]   m_ext;
  logic [EW-1:0]   neg_mag;
  logic [OUT_W-1:0] code_d;
  logic [OUT_W-1:0] code_q;

  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // magnitudes, squares, sums of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= magnitude(early_in_phase_i);
      mag_q[1] <= magnitude(early_quadrature_i);
      mag_q[2] <= magnitude(late_in_phase_i);
      mag_q[3] <= magnitude(late_quadrature_i);
      for (int k = 0; k < 4; k++) begin
        sq_q[k] <= XW'(mag_q[k]) * XW'(mag_q[k]);
      end
      rad_q[0] <= sq_q[0] + sq_q[1];
      rad_q[1] <= sq_q[2] + sq_q[3];
    end
  end

  // square root chain, early and late lanes side by side
  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    assign s_rem[ln][0]  = '0;
    assign s_root[ln][0] = '0;
    assign s_x[ln][0]    = rad_q[ln];
    for (genvar k = 0; k < SW; k++) begin : g_sqrt
      eled_sqrt_cell #(
        .SW   (SW),
        .STEP (SW - 1 - k)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (s_rem[ln][k]),
        .root_i (s_root[ln][k]),
        .x_i    (s_x[ln][k]),
        .rem_o  (s_rem[ln][k+1]),
        .root_o (s_root[ln][k+1]),
        .x_o    (s_x[ln][k+1])
      );
    end
  end

  // difference and sum of envelopes
  always_comb begin
    env_e      = s_root[0][SW];
    env_l      = s_root[1][SW];
    prep_diff  = (env_e >= env_l) ? (env_e - env_l) : (env_l - env_e);
    prep_s     = SUMW'(env_e) + SUMW'(env_l);
    prep_flags.neg  = (env_l > env_e);
    prep_flags.zero = (prep_s == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_rem[0]   <= DW'(prep_diff);
      d_s[0]     <= prep_s;
      d_flags[0] <= prep_flags;
    end
  end

  assign d_q[0] = '0;

  for (genvar k = 0; k < FB; k++) begin : g_div
    eled_div_cell #(
      .SW (SW),
      .FB (FB)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .rem_i   (d_rem[k]),
      .q_i     (d_q[k]),
      .s_i     (d_s[k]),
      .flags_i (d_flags[k]),
      .rem_o   (d_rem[k+1]),
      .q_o     (d_q[k+1]),
      .s_o     (d_s[k+1]),
      .flags_o (d_flags[k+1])
    );
  end

  // round to nearest, sign and saturate
  always_comb begin
    rnd     = (d_rem[FB] >= DW'(d_s[FB]));
    m       = MW'(d_q[FB]) + MW'(rnd);
    m_ext   = EW'(m);
    neg_mag = (m_ext > EW'(OUT_NEG_LIM)) ? EW'(OUT_NEG_LIM) : m_ext;
    if (d_flags[FB].zero) begin
      code_d = '0;
    end else if (d_flags[FB].neg) begin
      code_d = OUT_W'(EW'(0) - neg_mag);
    end else if (m_ext > EW'(OUT_MAX)) begin
      code_d = OUT_W'(OUT_MAX);
    end else begin
      code_d = m_ext[OUT_W-1:0];
    end
  end

  eled_out_buf #(
    .W (OUT_W)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NST-1]),
    .data_i  (code_d),
    .en_o    (en),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (code_q)
  );

  assign code_error_o = code_q;

  logic unused_sqrt_tail;
  assign unused_sqrt_tail = ^{s_rem[0][SW], s_rem[1][SW], s_x[0][SW], s_x[1][SW],
                              vld_q[SQ0], vld_q[PREP]};

endmodule
`default_nettype wire

### rtl/eled_sqrt_cell.sv
// one digit cell of the pipelined integer square root
`default_nettype none
module eled_sqrt_cell #(
  parameter int SW   = 24,
  parameter int STEP = 0
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [SW+1:0]     rem_i,
  input  wire logic [SW-1:0]     root_i,
  input  wire logic [2*SW-1:0]   x_i,
  output logic      [SW+1:0]     rem_o,
  output logic      [SW-1:0]     root_o,
  output logic      [2*SW-1:0]   x_o
);

  localparam int RW = SW + 2;

  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;
  logic            ge;
  logic [RW-1:0]   rem_d, rem_q;
  logic [SW-1:0]   root_d, root_q;
  logic [2*SW-1:0] x_q;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], x_i[2*STEP+1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[SW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      x_q    <= x_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign x_o    = x_q;

endmodule
`default_nettype wire

### rtl/eled_div_cell.sv
// one quotient-bit cell of the pipelined restoring divider
`default_nettype none
module eled_div_cell
  import eled_pkg::*;
#(
  parameter int SW = 24,
  parameter int FB = 15
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [SW+2:0] rem_i,
  input  wire logic [FB-1:0] q_i,
  input  wire logic [SW:0]   s_i,
  input  wire eled_flags_t   flags_i,
  output logic      [SW+2:0] rem_o,
  output logic      [FB-1:0] q_o,
  output logic      [SW:0]   s_o,
  output eled_flags_t        flags_o
);

  localparam int DW = SW + 3;

  logic [DW-1:0] sh;
  logic [DW-1:0] dv;
  logic          ge;
  logic [DW-1:0] rem_d, rem_q;
  logic [FB-1:0] q_d, q_q;
  logic [SW:0]   s_q;
  eled_flags_t   flags_q;

  always_comb begin
    sh    = {rem_i[DW-2:0], 1'b0};
    dv    = {1'b0, s_i, 1'b0};
    ge    = (sh >= dv);
    rem_d = ge ? (sh - dv) : sh;
    q_d   = {q_i[FB-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      q_q     <= q_d;
      s_q     <= s_i;
      flags_q <= flags_i;
    end
  end

  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign s_o     = s_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

### rtl/eled_out_buf.sv
// output register with one skid entry, holds the pipeline while full
`default_nettype none
module eled_out_buf #(
  parameter int W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [W-1:0] data_i,
  output logic              en_o,
  output logic              valid_o,
  input  wire logic         stall_i,
  output logic      [W-1:0] data_o
);

  logic         out_vld_q;
  logic         skid_vld_q;
  logic [W-1:0] out_q;
  logic [W-1:0] skid_q;
  logic         take;
  logic         load_out;
  logic         load_skid;

  always_comb begin
    take      = out_vld_q && !stall_i;
    load_out  = !skid_vld_q && valid_i && (!out_vld_q || take);
    load_skid = !skid_vld_q && valid_i && out_vld_q && !take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (load_skid) begin
      skid_vld_q <= 1'b1;
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q && take) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

  assign en_o    = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

### rtl/eled_checker.sv
// port-level checks of the discriminator handshake and hold behavior
`default_nettype none
module eled_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] code_error_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(code_error_o))
    else $error("output item changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output item");

  a_in_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output item pending");

  a_in_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_stall_i))
    else $error("input stall released without output item taken");

  logic unused_in;
  assign unused_in = in_valid_i;

endmodule

bind early_late_envelope_discriminator_top eled_checker u_eled_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_error_o (code_error_o)
);
`default_nettype wire
